>>> src/kbd_pkg.sv
// Package with shared types, codes and constants for the key debouncer.
package kbd_pkg;

  // Field and bus widths.
  localparam int unsigned KEYS_W      = 3;
  localparam int unsigned TICK_W      = 8;
  localparam int unsigned CODE_W      = 3;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_TICKS  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_DELAY    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_INTERVAL = 2'd2;

  // Configuration reset values.
  localparam logic [TICK_W-1:0]  DEBOUNCE_TICKS_RST  = 8'd20;
  localparam logic [COUNT_W-1:0] REPEAT_DELAY_RST    = 16'd600;
  localparam logic [COUNT_W-1:0] REPEAT_INTERVAL_RST = 16'd100;

  // Opcodes carried in tuser.
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Key codes.
  localparam logic [CODE_W-1:0] CODE_NONE     = 3'd0;
  localparam logic [CODE_W-1:0] CODE_KEY1     = 3'd1;
  localparam logic [CODE_W-1:0] CODE_KEY2     = 3'd2;
  localparam logic [CODE_W-1:0] CODE_KEY3     = 3'd3;
  localparam logic [CODE_W-1:0] CODE_FAST_INC = 3'd4;
  localparam logic [CODE_W-1:0] CODE_FAST_DEC = 3'd5;

  // Scan state machine.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_HELD = 2'd2
  } mode_e;

endpackage

>>> src/key_debounce_autorepeat.sv
// Three-key debouncer with auto-repeat and a two-entry result buffer.
// A scan transfer updates the state at its accept edge; a read transfer's key code is
// registered into the output register, or into the skid register while the output stalls.
// Throughput: one transfer per cycle, limited only by the two-entry output buffer
// (output register plus skid register) filling while the master side stalls.
// Reset: asynchronous, active low; registers other than the code registers return to their defaults, no pending code.
module key_debounce_autorepeat (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Slave side.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata, low bit up: key_bits[2:0], tick_count[10:3], zero fill[15:11].
  input  logic [kbd_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // tuser, low bit up: opcode[0].
  input  logic [kbd_pkg::IN_TUSER_W-1:0]   s_axis_tuser_i,
  // Master side.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata, low bit up: key_code[2:0], zero fill[7:3].
  output logic [kbd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [kbd_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [kbd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import kbd_pkg::*;

  // Configuration registers.
  logic [TICK_W-1:0]  debounce_q;
  logic [COUNT_W-1:0] delay_q;
  logic [COUNT_W-1:0] interval_q;

  // Scan state.
  mode_e              mode_q, mode_d;
  logic [KEYS_W-1:0]  captured_q, captured_d;
  logic [TICK_W-1:0]  stamp_q, stamp_d;
  logic [CODE_W-1:0]  pending_q, pending_d;
  logic [CODE_W-1:0]  held_q, held_d;
  logic [COUNT_W-1:0] repeat_q, repeat_d;

  // Output buffer.
  logic              out_valid_q, out_valid_d;
  logic [CODE_W-1:0] out_code_q, out_code_d;
  logic              skid_valid_q, skid_valid_d;
  logic [CODE_W-1:0] skid_code_q, skid_code_d;

  // Transfer decode.
  logic               s_xfer, m_xfer, push;
  logic               is_read;
  logic [KEYS_W-1:0]  keys;
  logic [TICK_W-1:0]  now;
  logic [TICK_W-1:0]  diff;
  logic               span_ok;
  logic [CODE_W-1:0]  press_code;
  logic [COUNT_W-1:0] repeat_dec;

  assign s_axis_tready_o = ~skid_valid_q;
  assign s_xfer          = s_axis_tvalid_i & s_axis_tready_o;
  assign m_xfer          = out_valid_q & m_axis_tready_i;
  assign is_read         = (s_axis_tuser_i[0] == OP_READ);
  assign push            = s_xfer & is_read;
  assign keys            = s_axis_tdata_i[KEYS_W-1:0];
  assign now             = s_axis_tdata_i[KEYS_W+TICK_W-1:KEYS_W];
  assign diff            = now - stamp_q;
  assign span_ok         = (diff >= debounce_q);
  assign repeat_dec      = (repeat_q != '0) ? repeat_q - COUNT_W'(1) : '0;

  // Press priority: key 3 over key 2 over key 1.
  always_comb begin
    press_code = CODE_NONE;
    if (captured_q[0]) press_code = CODE_KEY1;
    if (captured_q[1]) press_code = CODE_KEY2;
    if (captured_q[2]) press_code = CODE_KEY3;
  end

  // Configuration writes; an out-of-range index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_TICKS_RST;
      delay_q    <= REPEAT_DELAY_RST;
      interval_q <= REPEAT_INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_DEBOUNCE_TICKS:  debounce_q <= cfg_wdata_i[TICK_W-1:0];
        REG_REPEAT_DELAY:    delay_q    <= cfg_wdata_i[COUNT_W-1:0];
        REG_REPEAT_INTERVAL: interval_q <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state of the scan machine for the accepted transfer.
  always_comb begin
    mode_d     = mode_q;
    captured_d = captured_q;
    stamp_d    = stamp_q;
    pending_d  = pending_q;
    held_d     = held_q;
    repeat_d   = repeat_q;
    if (s_xfer) begin
      if (is_read) begin
        pending_d = CODE_NONE;
      end else begin
        unique case (mode_q)
          MODE_WAIT: begin
            if (captured_q != keys) begin
              mode_d = MODE_IDLE;
            end else if (span_ok) begin
              pending_d = press_code;
              held_d    = press_code;
              mode_d    = MODE_HELD;
              stamp_d   = now;
              repeat_d  = delay_q;
            end
          end
          MODE_HELD: begin
            if (keys != '0) begin
              stamp_d  = now;
              repeat_d = repeat_dec;
              // Counter ran out: post a repeat code unless key 1 is held.
              if (repeat_dec == '0 && held_q != CODE_KEY1) begin
                repeat_d  = interval_q;
                pending_d = (held_q == CODE_KEY2) ? CODE_FAST_INC : CODE_FAST_DEC;
              end
            end else if (span_ok) begin
              mode_d = MODE_IDLE;
            end
          end
          default: begin
            // Idle, and the unused encoding.
            mode_d = MODE_IDLE;
            if (keys != '0) begin
              captured_d = keys;
              mode_d     = MODE_WAIT;
              stamp_d    = now;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      captured_q <= '0;
      stamp_q    <= '0;
      pending_q  <= CODE_NONE;
      held_q     <= CODE_NONE;
      repeat_q   <= '0;
    end else begin
      mode_q     <= mode_d;
      captured_q <= captured_d;
      stamp_q    <= stamp_d;
      pending_q  <= pending_d;
      held_q     <= held_d;
      repeat_q   <= repeat_d;
    end
  end

  // Output register with a skid stage; the skid fills only while the output stalls.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_code_d   = out_code_q;
    skid_valid_d = skid_valid_q;
    skid_code_d  = skid_code_q;
    if (!out_valid_q || m_xfer) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_code_d   = skid_code_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
        out_code_d  = pending_q;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_code_d  = pending_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_code_q  <= out_code_d;
    skid_code_q <= skid_code_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-CODE_W){1'b0}}, out_code_q};

  // The skid stage never holds a code ahead of an empty output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a code while the output register is empty");

  // A read into an empty buffer shows the pending code on the next cycle.
  a_read_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !out_valid_q) |=> (out_valid_q && out_code_q == $past(pending_q)))
    else $error("read transfer did not reach the output register");

  // A read clears the pending code.
  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (pending_q == CODE_NONE))
    else $error("pending code not cleared by a read");

  // A latched key is always a real key code while held.
  a_held_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_HELD) |-> (held_q == CODE_KEY1 || held_q == CODE_KEY2 ||
                               held_q == CODE_KEY3))
    else $error("held state without a latched key");

  // Key 1 never leaves a repeat code behind.
  a_no_repeat_key1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && !is_read && mode_q == MODE_HELD && held_q == CODE_KEY1)
      |=> (pending_q == $past(pending_q)))
    else $error("key 1 produced a repeat code");

endmodule

>>> bench/kbd_checker.sv
// Checker that predicts the debouncer's key codes and compares them with the master side.
module kbd_checker
  import kbd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  // tdata, low bit up: key_bits[2:0], tick_count[10:3], zero fill[15:11].
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  // tuser, low bit up: opcode[0].
  input  logic [IN_TUSER_W-1:0]  s_tuser_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  // tdata, low bit up: key_code[2:0], zero fill[7:3].
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  output int                     errors_o,
  output int                     outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the configuration registers.
  logic [TICK_W-1:0]  debounce_span;
  logic [COUNT_W-1:0] first_repeat;
  logic [COUNT_W-1:0] next_repeat;

  // Shadow copy of the scan state.
  mode_e              mode;
  logic [KEYS_W-1:0]  latched_keys;
  logic [TICK_W-1:0]  stamp;
  logic [CODE_W-1:0]  unread_code;
  logic [CODE_W-1:0]  held_code;
  logic [COUNT_W-1:0] scans_to_repeat;

  // Key codes owed to the master side, oldest first.
  logic [CODE_W-1:0]  owed_codes[$];
  logic [CODE_W-1:0]  oldest;
  int                 errors;

  // True once the tick distance from the stamp covers the debounce span.
  function automatic logic span_covered(input logic [TICK_W-1:0] now);
    logic [TICK_W-1:0] elapsed;
    elapsed = now - stamp;
    return elapsed >= debounce_span;
  endfunction

  // Moves the scan state machine by one scan sample.
  task automatic advance_scan(input logic [KEYS_W-1:0] keys, input logic [TICK_W-1:0] now);
    logic [CODE_W-1:0] code;
    case (mode)
      MODE_WAIT: begin
        if (latched_keys != keys) begin
          mode = MODE_IDLE;
        end else if (span_covered(now)) begin
          // Highest key wins.
          code = CODE_NONE;
          if (latched_keys[0]) code = CODE_KEY1;
          if (latched_keys[1]) code = CODE_KEY2;
          if (latched_keys[2]) code = CODE_KEY3;
          unread_code     = code;
          held_code       = code;
          mode            = MODE_HELD;
          stamp           = now;
          scans_to_repeat = first_repeat;
        end
      end
      MODE_HELD: begin
        if (keys != '0) begin
          // Any pressed key keeps the hold alive and counts toward a repeat.
          stamp = now;
          if (scans_to_repeat != '0) scans_to_repeat = scans_to_repeat - 1'b1;
          if (scans_to_repeat == '0 && held_code != CODE_KEY1) begin
            scans_to_repeat = next_repeat;
            unread_code     = (held_code == CODE_KEY2) ? CODE_FAST_INC : CODE_FAST_DEC;
          end
        end else if (span_covered(now)) begin
          mode = MODE_IDLE;
        end
      end
      default: begin
        mode = MODE_IDLE;
        if (keys != '0) begin
          latched_keys = keys;
          mode         = MODE_WAIT;
          stamp        = now;
        end
      end
    endcase
  endtask

  // Watch both channels and the register port on every edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_span   = DEBOUNCE_TICKS_RST;
      first_repeat    = REPEAT_DELAY_RST;
      next_repeat     = REPEAT_INTERVAL_RST;
      mode            = MODE_IDLE;
      latched_keys    = '0;
      stamp           = '0;
      unread_code     = CODE_NONE;
      held_code       = CODE_NONE;
      scans_to_repeat = '0;
      owed_codes.delete();
      errors          = 0;
    end else begin
      // A result transfer is matched with the oldest owed code.
      if (m_tvalid_i && m_tready_i) begin
        if (owed_codes.size() == 0) begin
          errors++;
          $display("%0t: unexpected key code transfer, expected none, actual %0d",
                   $time, m_tdata_i[CODE_W-1:0]);
        end else begin
          oldest = owed_codes.pop_front();
          if (m_tdata_i[CODE_W-1:0] != oldest) begin
            errors++;
            $display("%0t: key code mismatch, expected %0d, actual %0d",
                     $time, oldest, m_tdata_i[CODE_W-1:0]);
          end
        end
      end
      // An input transfer either reads the pending code or moves the scan state.
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i[0] == OP_READ) begin
          owed_codes.push_back(unread_code);
          unread_code = CODE_NONE;
        end else begin
          advance_scan(s_tdata_i[KEYS_W-1:0], s_tdata_i[KEYS_W +: TICK_W]);
        end
      end
      // Register writes take effect after this edge's transfer.
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_DEBOUNCE_TICKS:  debounce_span = cfg_wdata_i[TICK_W-1:0];
          REG_REPEAT_DELAY:    first_repeat  = cfg_wdata_i[COUNT_W-1:0];
          REG_REPEAT_INTERVAL: next_repeat   = cfg_wdata_i[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
    errors_o      <= errors;
    outstanding_o <= owed_codes.size();
  end

endmodule

>>> bench/tb.sv
// Top of the key debouncer testbench: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kbd_pkg::*;

  // Register index that the block does not decode.
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [IN_TUSER_W-1:0]  s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  int                     err_count;
  int                     outstanding;

  // Stimulus bookkeeping.
  bit                     stalls_on;
  int                     stall_left;
  int                     items_sent;
  logic [TICK_W-1:0]      tick;
  logic [TICK_W-1:0]      span_now;
  logic [COUNT_W-1:0]     delay_now;
  logic [COUNT_W-1:0]     interval_now;

  key_debounce_autorepeat DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  kbd_checker u_code_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tuser_i     (s_tuser),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .errors_o      (err_count),
    .outstanding_o (outstanding)
  );

  // Free-running clock, 20 ns period.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the handshakes hang.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Master side: ready drops in random bursts while stalls are enabled.
  initial begin
    m_tready   = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (!stalls_on) stall_left = 0;
      else if (stall_left == 0 && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 9);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // One input transfer, with an optional random gap before it.
  task automatic send_item(input logic op, input logic [KEYS_W-1:0] keys,
                           input logic [TICK_W-1:0] ticks);
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_TDATA_W-KEYS_W-TICK_W){1'b0}}, ticks, keys};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Read transfer; its key and tick fields carry random junk.
  task automatic read_code();
    send_item(OP_READ, KEYS_W'($urandom), TICK_W'($urandom));
  endtask

  // Scan transfer, sometimes preceded by a read.
  task automatic scan_keys(input logic [KEYS_W-1:0] keys, input logic [TICK_W-1:0] ticks);
    if ($urandom_range(0, 3) == 0) read_code();
    send_item(OP_SCAN, keys, ticks);
  endtask

  // Stop sending until every owed key code has come back, then let the block settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One register write, after which the enable is driven low again.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes all registers; the unused index and the high debounce bits get junk.
  task automatic set_config(input logic [TICK_W-1:0] span, input logic [COUNT_W-1:0] delay,
                            input logic [COUNT_W-1:0] interval);
    write_reg(REG_DEBOUNCE_TICKS, {8'($urandom), span});
    write_reg(REG_REPEAT_DELAY, delay);
    write_reg(REG_REPEAT_INTERVAL, interval);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    span_now     = span;
    delay_now    = delay;
    interval_now = interval;
  endtask

  // A press, hold and release with random content and the odd bounce.
  task automatic press_sequence();
    logic [KEYS_W-1:0] pattern;
    logic [TICK_W-1:0] t0;
    int                n;
    int                hold_max;
    int                off;
    pattern = KEYS_W'($urandom_range(1, 7));
    tick    = TICK_W'(tick + $urandom_range(0, 255));
    t0      = tick;
    scan_keys(pattern, t0);
    // Samples inside the debounce span, now and then with a different pattern.
    n = $urandom_range(0, 3);
    repeat (n) begin
      off = (span_now == 0) ? 0 : $urandom_range(0, span_now - 1);
      if ($urandom_range(0, 9) == 0) scan_keys(KEYS_W'($urandom_range(0, 7)), TICK_W'(t0 + off));
      else scan_keys(pattern, TICK_W'(t0 + off));
    end
    if (span_now != 0 && $urandom_range(0, 7) == 0) begin
      scan_keys(pattern, TICK_W'(t0 + span_now - 1));
    end
    tick = t0 + span_now;
    scan_keys(pattern, tick);
    // Hold long enough to reach a few repeats when the counts are small.
    hold_max = 4 + 2 * ((delay_now < 16) ? delay_now : 16)
                 + 2 * ((interval_now < 8) ? interval_now : 8);
    n = $urandom_range(0, hold_max);
    repeat (n) begin
      tick = TICK_W'(tick + $urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) scan_keys(KEYS_W'($urandom_range(1, 7)), tick);
      else scan_keys(pattern, tick);
    end
    // Release, sometimes with a bounce back to pressed.
    n = $urandom_range(0, 2);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) begin
        tick = TICK_W'(tick + $urandom_range(0, 3));
        scan_keys(pattern, tick);
      end else if (span_now != 0) begin
        scan_keys('0, TICK_W'(tick + $urandom_range(0, span_now - 1)));
      end
    end
    tick = tick + span_now;
    scan_keys('0, tick);
    read_code();
  endtask

  // A few fully random transfers.
  task automatic noise_burst();
    repeat ($urandom_range(1, 5))
      send_item(1'($urandom_range(0, 1)), KEYS_W'($urandom_range(0, 7)),
                TICK_W'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int target;
    int waited;
    rst_ni     = 1'b0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    stalls_on  = 1'b1;
    items_sent = 0;
    tick       = '0;
    span_now     = DEBOUNCE_TICKS_RST;
    delay_now    = REPEAT_DELAY_RST;
    interval_now = REPEAT_INTERVAL_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: key 3 press that just misses, then meets the span, and its release.
    send_item(OP_READ, 3'h7, 8'hFF);
    send_item(OP_SCAN, 3'b100, 8'd0);
    send_item(OP_SCAN, 3'b100, 8'd19);
    send_item(OP_SCAN, 3'b100, 8'd20);
    send_item(OP_READ, 3'h0, 8'h00);
    send_item(OP_SCAN, 3'b000, 8'd30);
    send_item(OP_SCAN, 3'b000, 8'd40);
    send_item(OP_READ, 3'h5, 8'hA5);
    drain_results();

    // Zero repeat counts: tick wrap, key 1 never repeats, pattern change in wait and hold,
    // an unread code overwritten by a repeat.
    set_config(8'd5, 16'd0, 16'd0);
    send_item(OP_SCAN, 3'b001, 8'd250);
    send_item(OP_SCAN, 3'b001, 8'd3);
    send_item(OP_SCAN, 3'b111, 8'd4);
    send_item(OP_READ, 3'h2, 8'h5A);
    send_item(OP_SCAN, 3'b000, 8'd6);
    send_item(OP_SCAN, 3'b000, 8'd9);
    send_item(OP_SCAN, 3'b010, 8'd100);
    send_item(OP_SCAN, 3'b110, 8'd101);
    send_item(OP_SCAN, 3'b010, 8'd102);
    send_item(OP_SCAN, 3'b010, 8'd107);
    send_item(OP_SCAN, 3'b010, 8'd108);
    send_item(OP_READ, 3'h0, 8'h00);
    send_item(OP_READ, 3'h7, 8'hFF);
    send_item(OP_SCAN, 3'b110, 8'd110);
    send_item(OP_SCAN, 3'b000, 8'd255);
    send_item(OP_SCAN, 3'b111, 8'd0);
    send_item(OP_SCAN, 3'b111, 8'd5);
    send_item(OP_SCAN, 3'b111, 8'd5);
    send_item(OP_READ, 3'h1, 8'h80);

    // Random phases, each under its own register settings.
    for (int p = 0; p < 9; p++) begin
      drain_results();
      case (p)
        0: set_config(8'd0, 16'd0, 16'd0);
        1: set_config(8'd255, 16'hFFFF, 16'hFFFF);
        2: set_config(8'd1, 16'd1, 16'd0);
        3: set_config(8'd255, 16'd0, 16'd1);
        4: set_config(DEBOUNCE_TICKS_RST, REPEAT_DELAY_RST, REPEAT_INTERVAL_RST);
        default: set_config(TICK_W'($urandom_range(0, 255)), COUNT_W'($urandom_range(0, 10)),
                            COUNT_W'($urandom_range(0, 6)));
      endcase
      stalls_on = (p == 8) ? 1'b0 : ($urandom_range(0, 3) != 0);
      target = items_sent + 135;
      while (items_sent < target) begin
        if ($urandom_range(0, 4) == 0) noise_burst();
        else press_sequence();
      end
    end

    // Wait for the last key codes, then let the block settle.
    s_tvalid <= 1'b0;
    waited = 0;
    @(posedge clk_i);
    while (outstanding != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (err_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/kbd_pkg.sv
src/key_debounce_autorepeat.sv
bench/kbd_checker.sv
bench/tb.sv
